// ===== sv/cpl_pkg.sv =====
// Package with the word types, parse phases, status codes and character constants.
package cpl_pkg;

    // Width of the value field in a result word.
    localparam int unsigned OUT_VALUE_W = 32;

    // Parse phase of the token being read.
    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_U       = 3'd1,
        PH_ZERO    = 3'd2,
        PH_DEC     = 3'd3,
        PH_HEXNEED = 3'd4,
        PH_HEX     = 3'd5,
        PH_OCT     = 3'd6,
        PH_BAD     = 3'd7
    } phase_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_TOO_LARGE = 2'd2
    } status_t;

    // Radix selection for the accumulate step.
    typedef enum logic [1:0] {
        RADIX_8  = 2'd0,
        RADIX_10 = 2'd1,
        RADIX_16 = 2'd2
    } radix_t;

    // Character codes the parser looks for.
    localparam logic [7:0] CH_U_UP  = 8'h55;
    localparam logic [7:0] CH_U_LO  = 8'h75;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;

    // Input word: one character of a token.
    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
    } in_t;

    // Result word: value and status of a finished token.
    typedef struct packed {
        logic [OUT_VALUE_W-1:0] value;
        status_t                status;
    } out_t;

    // Parse flags carried between the step logic and the state registers.
    typedef struct packed {
        phase_t phase;
        logic   too_large;
        logic   octal_stopped;
        logic   malformed;
    } flags_t;

endpackage

// ===== sv/cpl_step.sv =====
// Per-character parse step: phase transition and radix accumulate with overflow check.
module cpl_step
    import cpl_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32
) (
    input  flags_t                flags_cur,
    input  logic [VALUE_BITS-1:0] acc_cur,
    input  logic [7:0]            ch,
    input  logic                  has_char,
    output flags_t                flags_next,
    output logic [VALUE_BITS-1:0] acc_next
);

    localparam int unsigned SUM_W = VALUE_BITS + 5;

    logic                 is_dec;
    logic                 is_hex_lo;
    logic                 is_hex_up;
    logic                 is_hex;
    logic [3:0]           digit;
    logic                 add_en;
    radix_t               radix;
    flags_t               flags_parse;
    logic [SUM_W-1:0]     acc_ext;
    logic [SUM_W-1:0]     scaled;
    logic [SUM_W-1:0]     sum;
    logic                 overflow;

    // Character classes and digit value.
    assign is_dec    = (ch >= CH_0) && (ch <= CH_9);
    assign is_hex_lo = (ch >= CH_A_LO) && (ch <= CH_F_LO);
    assign is_hex_up = (ch >= CH_A_UP) && (ch <= CH_F_UP);
    assign is_hex    = is_dec || is_hex_lo || is_hex_up;
    assign digit     = is_dec ? ch[3:0] : (ch[3:0] + 4'd9);

    // Multiply by the radix with shifts, then add the digit.
    assign acc_ext = {5'b0, acc_cur};
    always_comb begin
        case (radix)
            RADIX_8:  scaled = acc_ext << 3;
            RADIX_10: scaled = (acc_ext << 3) + (acc_ext << 1);
            RADIX_16: scaled = acc_ext << 4;
            default:  scaled = acc_ext << 4;
        endcase
    end
    assign sum      = scaled + {{(SUM_W-4){1'b0}}, digit};
    assign overflow = |sum[SUM_W-1:VALUE_BITS];

    // Phase transitions for one character.
    always_comb begin
        flags_parse = flags_cur;
        add_en      = 1'b0;
        radix       = RADIX_10;
        if (has_char) begin
            unique case (flags_cur.phase) inside
                PH_START: begin
                    if (ch == CH_U_UP || ch == CH_U_LO) begin
                        flags_parse.phase = PH_U;
                    end else if (ch == CH_0) begin
                        flags_parse.phase = PH_ZERO;
                    end else if (is_dec) begin
                        flags_parse.phase = PH_DEC;
                        add_en            = 1'b1;
                    end else begin
                        flags_parse.phase     = PH_BAD;
                        flags_parse.malformed = 1'b1;
                    end
                end
                PH_U: begin
                    if (ch == CH_PLUS || ch == CH_MINUS) begin
                        flags_parse.phase = PH_HEXNEED;
                    end else begin
                        flags_parse.phase     = PH_BAD;
                        flags_parse.malformed = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (ch == CH_X_LO || ch == CH_X_UP) begin
                        flags_parse.phase = PH_HEXNEED;
                    end else if (is_dec) begin
                        flags_parse.phase = PH_OCT;
                        radix             = RADIX_8;
                        if (ch >= CH_8) begin
                            flags_parse.octal_stopped = 1'b1;
                        end else begin
                            add_en = 1'b1;
                        end
                    end else begin
                        flags_parse.phase     = PH_BAD;
                        flags_parse.malformed = 1'b1;
                    end
                end
                PH_DEC: begin
                    if (is_dec) begin
                        add_en = 1'b1;
                    end else begin
                        flags_parse.phase     = PH_BAD;
                        flags_parse.malformed = 1'b1;
                    end
                end
                PH_HEXNEED, PH_HEX: begin
                    radix = RADIX_16;
                    if (is_hex) begin
                        flags_parse.phase = PH_HEX;
                        add_en            = 1'b1;
                    end else begin
                        flags_parse.phase     = PH_BAD;
                        flags_parse.malformed = 1'b1;
                    end
                end
                PH_OCT: begin
                    radix = RADIX_8;
                    if (!is_dec) begin
                        flags_parse.phase     = PH_BAD;
                        flags_parse.malformed = 1'b1;
                    end else if (flags_cur.octal_stopped) begin
                        add_en = 1'b0;
                    end else if (ch >= CH_8) begin
                        flags_parse.octal_stopped = 1'b1;
                    end else begin
                        add_en = 1'b1;
                    end
                end
                default: begin
                    flags_parse.phase     = PH_BAD;
                    flags_parse.malformed = 1'b1;
                end
            endcase
        end
    end

    // Accumulate unless the value has already overflowed; overflow freezes it.
    always_comb begin
        flags_next = flags_parse;
        acc_next   = acc_cur;
        if (add_en && !flags_cur.too_large) begin
            if (overflow) begin
                flags_next.too_large = 1'b1;
            end else begin
                acc_next = sum[VALUE_BITS-1:0];
            end
        end
    end

endmodule

// ===== sv/code_point_literal_parser.sv =====
// Top level of the code point literal parser: input register, parse state, result register.
//
//   Channel | Ports                        | Moves
//   --------+------------------------------+-----------------------------------------
//   input   | s_valid, s_ready, s_data     | one token character word (ch, has_char, last)
//   result  | m_valid, m_ready, m_data     | one value/status word per token
//
// One word is taken per cycle unless a token end waits on a stalled result; the parse
// step for a word is combinational logic between the input register and the state and
// result registers. aresetn is synchronous and active low; it clears the valid flags
// and the parse state. A stalled result only holds back a word that ends a token; other
// words keep flowing while the result register waits.
module code_point_literal_parser
    import cpl_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    in_t                   in_reg;
    flags_t                flags_reg;
    flags_t                flags_next;
    logic [VALUE_BITS-1:0] acc_reg;
    logic [VALUE_BITS-1:0] acc_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_t                  out_reg;
    out_t                  out_next;

    flags_t                flags_step;
    logic [VALUE_BITS-1:0] acc_step;
    logic                  advance;
    logic                  end_bad;
    status_t               end_status;
    logic [VALUE_BITS+OUT_VALUE_W-1:0] acc_wide;

    // The held word moves on unless it ends a token and the result register is stuck.
    assign advance = in_valid_reg && (!in_reg.last || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Parse step for the held word.
    cpl_step #(
        .VALUE_BITS(VALUE_BITS)
    ) u_step (
        .flags_cur (flags_reg),
        .acc_cur   (acc_reg),
        .ch        (in_reg.ch),
        .has_char  (in_reg.has_char),
        .flags_next(flags_step),
        .acc_next  (acc_step)
    );

    // End-of-token check and result formation.
    assign end_bad = flags_step.malformed || flags_step.phase == PH_START ||
                     flags_step.phase == PH_U || flags_step.phase == PH_HEXNEED ||
                     flags_step.phase == PH_BAD;
    assign acc_wide = {{OUT_VALUE_W{1'b0}}, acc_step};
    always_comb begin
        if (end_bad) begin
            end_status = ST_MALFORMED;
        end else if (flags_step.too_large) begin
            end_status = ST_TOO_LARGE;
        end else begin
            end_status = ST_OK;
        end
    end

    // Next values of the input, state and result registers.
    always_comb begin
        in_valid_next  = in_valid_reg && !advance;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
        flags_next     = flags_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        if (advance) begin
            if (in_reg.last) begin
                flags_next.phase         = PH_START;
                flags_next.too_large     = 1'b0;
                flags_next.octal_stopped = 1'b0;
                flags_next.malformed     = 1'b0;
                acc_next                 = '0;
                out_valid_next           = 1'b1;
                out_next.status          = end_status;
                out_next.value           = (end_status == ST_OK) ?
                                           acc_wide[OUT_VALUE_W-1:0] : '0;
            end else begin
                flags_next = flags_step;
                acc_next   = acc_step;
            end
        end
    end

    // Control and parse state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            flags_reg.phase         <= PH_START;
            flags_reg.too_large     <= 1'b0;
            flags_reg.octal_stopped <= 1'b0;
            flags_reg.malformed     <= 1'b0;
            acc_reg                 <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            flags_reg     <= flags_next;
            acc_reg       <= acc_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // A finished token leaves the parse state clean for the next one.
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_reg.last |=> flags_reg.phase == PH_START && acc_reg == '0 &&
        !flags_reg.too_large && !flags_reg.malformed && !flags_reg.octal_stopped)
        else $error("parse state not cleared after token end");

    // The malformed flag is only ever set together with the bad phase.
    a_bad_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        flags_reg.malformed |-> flags_reg.phase == PH_BAD)
        else $error("malformed flag outside bad phase");

    // Octal stop only happens while reading an octal token, and stays if it turns bad.
    a_oct_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        flags_reg.octal_stopped |-> flags_reg.phase == PH_OCT || flags_reg.phase == PH_BAD)
        else $error("octal stop outside octal phase");

    // A failed token always reports a zero value.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.value == '0)
        else $error("nonzero value with error status");

    // A token end never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && in_reg.last && out_valid_reg && !m_ready |-> !advance)
        else $error("pending result overwritten");

endmodule

// ===== dv/code_point_literal_parser_tb.sv =====
// Self-checking testbench for the code point literal parser, with its own token predictor.
module code_point_literal_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpl_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned MIXED_WORDS  = 560;
    localparam int unsigned TOTAL_WORDS  = 660;
    localparam int unsigned LONG_HOLD    = 250;
    localparam logic [63:0] CODE_LIMIT   = 64'h0000_0000_FFFF_FFFF;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Predictor state for the token being read.
    phase_t      tok_phase    = PH_START;
    logic [63:0] tok_acc      = '0;
    bit          tok_big      = 1'b0;
    bit          tok_oct_stop = 1'b0;
    bit          tok_bad      = 1'b0;

    // Results still owed by the block, oldest first.
    out_t        pending_tokens[$];
    out_t        want_word;

    // Characters of the next token to send.
    logic [7:0]  tok_chars[$];

    // Traffic shaping shared by the sender and the receiver.
    bit          tx_gaps      = 1'b1;
    bit          rx_stalls    = 1'b1;
    int unsigned hold_request = 0;

    int unsigned cycle_count  = 0;
    int unsigned n_words      = 0;
    int unsigned n_tokens     = 0;
    int unsigned n_ok         = 0;
    int unsigned n_malformed  = 0;
    int unsigned n_big        = 0;
    int unsigned n_checked    = 0;
    int unsigned n_errors     = 0;

    code_point_literal_parser u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock: 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("code_point_literal_parser_tb: errors");
            $finish;
        end
    end

    // Decimal digit test.
    function automatic bit is_dec(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // Hex digit value, or -1 for any other byte.
    function automatic int hex_digit(input logic [7:0] c);
        if (is_dec(c)) return int'(c - CH_0);
        if (c >= CH_A_LO && c <= CH_F_LO) return int'(c - CH_A_LO) + 10;
        if (c >= CH_A_UP && c <= CH_F_UP) return int'(c - CH_A_UP) + 10;
        return -1;
    endfunction

    // Shift one digit into the value; past the limit the value freezes and the flag sticks.
    task automatic accumulate(input logic [63:0] radix, input logic [63:0] d);
        if (!tok_big) begin
            if (tok_acc > (CODE_LIMIT - d) / radix) tok_big = 1'b1;
            else tok_acc = tok_acc * radix + d;
        end
    endtask

    task automatic go_bad();
        tok_bad   = 1'b1;
        tok_phase = PH_BAD;
    endtask

    // Advance the parse by one character.
    task automatic parse_char(input logic [7:0] c);
        int h;
        h = hex_digit(c);
        case (tok_phase)
            PH_START: begin
                if (c == CH_U_UP || c == CH_U_LO) tok_phase = PH_U;
                else if (c == CH_0) tok_phase = PH_ZERO;
                else if (is_dec(c)) begin
                    tok_phase = PH_DEC;
                    accumulate(64'd10, 64'(c - CH_0));
                end else go_bad();
            end
            PH_U: begin
                if (c == CH_PLUS || c == CH_MINUS) tok_phase = PH_HEXNEED;
                else go_bad();
            end
            PH_ZERO: begin
                if (c == CH_X_LO || c == CH_X_UP) tok_phase = PH_HEXNEED;
                else if (is_dec(c)) begin
                    tok_phase = PH_OCT;
                    if (c >= CH_8) tok_oct_stop = 1'b1;
                    else accumulate(64'd8, 64'(c - CH_0));
                end else go_bad();
            end
            PH_DEC: begin
                if (is_dec(c)) accumulate(64'd10, 64'(c - CH_0));
                else go_bad();
            end
            PH_HEXNEED, PH_HEX: begin
                if (h >= 0) begin
                    tok_phase = PH_HEX;
                    accumulate(64'd16, 64'(h));
                end else go_bad();
            end
            PH_OCT: begin
                // After an 8 or 9 the remaining digits are only checked.
                if (!is_dec(c)) go_bad();
                else if (tok_oct_stop) begin
                end else if (c >= CH_8) tok_oct_stop = 1'b1;
                else accumulate(64'd8, 64'(c - CH_0));
            end
            default: go_bad();
        endcase
    endtask

    // Apply one accepted word; a closing word queues the token's result and clears the state.
    task automatic predict_word(input in_t w);
        out_t r;
        if (w.has_char) parse_char(w.ch);
        if (w.last) begin
            if (tok_phase inside {PH_START, PH_U, PH_HEXNEED, PH_BAD}) tok_bad = 1'b1;
            if (tok_bad) r.status = ST_MALFORMED;
            else if (tok_big) r.status = ST_TOO_LARGE;
            else r.status = ST_OK;
            r.value = (r.status == ST_OK) ? tok_acc[OUT_VALUE_W-1:0] : '0;
            pending_tokens.push_back(r);
            n_tokens++;
            case (r.status)
                ST_OK:        n_ok++;
                ST_MALFORMED: n_malformed++;
                default:      n_big++;
            endcase
            tok_phase    = PH_START;
            tok_acc      = '0;
            tok_big      = 1'b0;
            tok_oct_stop = 1'b0;
            tok_bad      = 1'b0;
        end
    endtask

    // Offer one word, hold it until accepted, then maybe leave a gap.
    task automatic send_word(input logic [7:0] c, input bit has, input bit fin);
        in_t w;
        w.ch       = c;
        w.has_char = has;
        w.last     = fin;
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_word(w);
        n_words++;
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // Send the queued characters as one token, optionally with idle words mixed in
    // and optionally closed by a word that carries no character.
    task automatic send_token(input bit close_empty, input bit with_idle);
        int n;
        n = tok_chars.size();
        if (n == 0) begin
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end else begin
            for (int i = 0; i < n; i++) begin
                if (with_idle && $urandom_range(0, 9) == 0)
                    send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                send_word(tok_chars[i], 1'b1, (i == n - 1) && !close_empty);
            end
            if (close_empty) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        tok_chars.delete();
    endtask

    task automatic push_text(input string t);
        for (int i = 0; i < t.len(); i++) tok_chars.push_back(t[i]);
    endtask

    function automatic logic [7:0] digit_char(input int unsigned d);
        return CH_0 + d[7:0];
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int unsigned v;
        v = $urandom_range(0, 15);
        if (v < 10) return digit_char(v);
        return ($urandom_range(0, 1) ? CH_A_LO : CH_A_UP) + 8'(v - 10);
    endfunction

    // Hex body: mostly up to eight digits, sometimes long enough to overflow.
    task automatic push_hex_body();
        int unsigned n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
        repeat (n) tok_chars.push_back(rand_hex_char());
    endtask

    task automatic push_decimal();
        int unsigned n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 11) : $urandom_range(1, 9);
        tok_chars.push_back(digit_char($urandom_range(1, 9)));
        repeat (n - 1) tok_chars.push_back(digit_char($urandom_range(0, 9)));
    endtask

    // One random token: mostly well-formed, the rest broken forms and noise.
    task automatic build_random_token();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(0, 99);
        if (kind < 18) begin
            tok_chars.push_back($urandom_range(0, 1) ? CH_U_UP : CH_U_LO);
            tok_chars.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            push_hex_body();
        end else if (kind < 36) begin
            tok_chars.push_back(CH_0);
            tok_chars.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
            push_hex_body();
        end else if (kind < 54) begin
            push_decimal();
        end else if (kind < 66) begin
            tok_chars.push_back(CH_0);
            n = $urandom_range(1, 12);
            repeat (n) begin
                if ($urandom_range(0, 9) == 0) tok_chars.push_back(CH_8 + 8'($urandom_range(0, 1)));
                else tok_chars.push_back(digit_char($urandom_range(0, 7)));
            end
        end else if (kind < 70) begin
            tok_chars.push_back(CH_0);
        end else if (kind < 78) begin
            // Prefix with nothing after it, a lone U, or nothing at all.
            case ($urandom_range(0, 3))
                0: begin
                    tok_chars.push_back($urandom_range(0, 1) ? CH_U_UP : CH_U_LO);
                    tok_chars.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                end
                1: tok_chars.push_back($urandom_range(0, 1) ? CH_U_UP : CH_U_LO);
                2: begin
                    tok_chars.push_back(CH_0);
                    tok_chars.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
                end
                default: ;
            endcase
        end else if (kind < 90) begin
            // A well-formed token with one byte replaced at random.
            if ($urandom_range(0, 1)) push_decimal();
            else begin
                tok_chars.push_back(CH_U_UP);
                tok_chars.push_back(CH_PLUS);
                push_hex_body();
            end
            tok_chars[$urandom_range(0, tok_chars.size() - 1)] = 8'($urandom_range(0, 255));
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) tok_chars.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_random_tokens(input int unsigned word_target);
        while (n_words < word_target) begin
            build_random_token();
            send_token($urandom_range(0, 7) == 0, 1'b1);
        end
    endtask

    // Receiver: random stalls, and a long hold whenever one is requested.
    initial begin
        while (!aresetn) @(posedge aclk);
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                m_ready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
                m_ready <= 1'b1;
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each delivered result word with the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_tokens.size() == 0) begin
                $error("result word with none expected: value %h status %0d",
                       m_data.value, m_data.status);
                n_errors++;
            end else begin
                want_word = pending_tokens.pop_front();
                n_checked++;
                if (m_data.value !== want_word.value) begin
                    $error("value: expected %h, got %h", want_word.value, m_data.value);
                    n_errors++;
                end
                if (m_data.status !== want_word.status) begin
                    $error("status: expected %0d, got %0d", want_word.status, m_data.status);
                    n_errors++;
                end
            end
        end
    end

    // Extremes of the fields and each corner of the token grammar.
    task automatic test_directed();
        send_token(1'b0, 1'b0);                     // empty token
        push_text("0");                  send_token(1'b0, 1'b0);
        push_text("U+");                 send_token(1'b0, 1'b0);
        push_text("u");                  send_token(1'b1, 1'b0);
        push_text("0x");                 send_token(1'b0, 1'b0);
        tok_chars.push_back(8'h00);      send_token(1'b0, 1'b0);
        tok_chars.push_back(8'hFF);      send_token(1'b0, 1'b0);
        push_text("078");                send_token(1'b0, 1'b0);
        push_text("09");                 send_token(1'b1, 1'b0);
        push_text("u-Af");               send_token(1'b0, 1'b1);
        push_text("0XFFFFFFFF");         send_token(1'b0, 1'b0);
        // Overflow followed by a bad character: malformed takes priority.
        push_text("0x123456789g");       send_token(1'b0, 1'b0);
    endtask

    task automatic test_random_mix();
        send_random_tokens(MIXED_WORDS);
    endtask

    // Hold the result side for a long stretch while short tokens keep coming.
    task automatic test_backpressure();
        rx_stalls = 1'b0;
        tx_gaps   = 1'b0;
        hold_request = LONG_HOLD;
        s_valid <= 1'b0;
        while (m_ready) @(posedge aclk);
        repeat (40) begin
            tok_chars.push_back(digit_char($urandom_range(0, 9)));
            send_token(1'b0, 1'b0);
        end
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    // Last stretch at full rate on both sides.
    task automatic test_steady();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        send_random_tokens(TOTAL_WORDS);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_mix();
        test_backpressure();
        test_steady();
        s_valid <= 1'b0;

        while (pending_tokens.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d words in %0d tokens (%0d ok, %0d malformed, %0d too large).",
                 n_words, n_tokens, n_ok, n_malformed, n_big);
        $display("Checked %0d results under idle bursts and a %0d-cycle result hold.",
                 n_checked, LONG_HOLD);
        if (n_errors == 0) begin
            $display("code_point_literal_parser_tb: clean");
        end else begin
            $display("code_point_literal_parser_tb: errors");
        end
        $finish;
    end

endmodule
